>>> rtl/core/htcc_pkg.sv
// ----------------------------------------------------------------------------
// htcc_pkg
// Shared types, constants and checksum helpers for the humidity and
// temperature compensation block.
// ----------------------------------------------------------------------------
package htcc_pkg;

	localparam int FRACTION_BITS = 24;
	localparam int DIVISOR       = 100;

	localparam logic [7:0]  CRC_POLY       = 8'h31;
	localparam logic [7:0]  TEMP_CMD_RESET = 8'd3;
	localparam logic [7:0]  HUMI_CMD_RESET = 8'd5;

	localparam int          CFG_INDEX_W  = 2;
	localparam logic [1:0]  CFG_TEMP_CMD = 2'd0;
	localparam logic [1:0]  CFG_HUMI_CMD = 2'd1;

	localparam logic [16:0] TEMP_OFFSET = 17'd4000;
	localparam logic [15:0] DT_OFFSET   = 16'd6500;
	localparam logic [13:0] HUMI_MIN    = 14'd10;
	localparam logic [13:0] HUMI_MAX    = 14'd10000;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [7:0]  temp_checksum;
		logic [15:0] raw_humidity;
		logic [7:0]  humi_checksum;
	} sample_t;

	typedef struct packed {
		logic signed [16:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic               temp_crc_ok;
		logic               humi_crc_ok;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[7 - k] = v[k];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/htcc_div100.sv
// ----------------------------------------------------------------------------
// htcc_div100
// Pipelined restoring division of an unsigned word by the package divisor,
// up to eight quotient bits per stage, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module htcc_div100 #(
	parameter int WIDTH  = 43,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WIDTH-1:0]  in_dividend,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WIDTH-1:0]  out_quotient,
	output logic [SIDE_W-1:0] out_side
);

	localparam int K     = (WIDTH + 7) / 8;
	localparam int REM_W = $clog2(htcc_pkg::DIVISOR);
	localparam logic [REM_W:0] DIV_V = (REM_W + 1)'(htcc_pkg::DIVISOR);

	logic [WIDTH-1:0]  work_s [K];
	logic [REM_W-1:0]  rem_s  [K];
	logic [SIDE_W-1:0] side_s [K];
	logic [K-1:0]      vld_s;
	logic [K-1:0]      adv;

	for (genvar k = 0; k < K; k++) begin : g_stage
		localparam int STEPS = (WIDTH - 8 * k < 8) ? (WIDTH - 8 * k) : 8;

		logic [WIDTH-1:0]  work_in;
		logic [REM_W-1:0]  rem_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [WIDTH-1:0]  work_nx;
		logic [REM_W-1:0]  rem_nx;

		if (k == 0) begin : g_first
			assign work_in = in_dividend;
			assign rem_in  = '0;
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign work_in = work_s[k - 1];
			assign rem_in  = rem_s[k - 1];
			assign side_in = side_s[k - 1];
			assign vld_in  = vld_s[k - 1];
		end

		if (k == K - 1) begin : g_last
			assign adv[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k + 1];
		end

		always_comb begin
			logic [WIDTH-1:0] w;
			logic [REM_W:0]   t;
			logic [REM_W-1:0] r;
			w = work_in;
			r = rem_in;
			for (int j = 0; j < STEPS; j++) begin
				t = {r, w[WIDTH-1]};
				w = {w[WIDTH-2:0], 1'b0};
				if (t >= DIV_V) begin
					t    = t - DIV_V;
					w[0] = 1'b1;
				end
				r = t[REM_W-1:0];
			end
			work_nx = w;
			rem_nx  = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				work_s[k] <= work_nx;
				rem_s[k]  <= rem_nx;
				side_s[k] <= side_in;
			end
		end
	end

	assign in_ready     = adv[0];
	assign out_valid    = vld_s[K-1];
	assign out_quotient = work_s[K-1];
	assign out_side     = side_s[K-1];

endmodule

>>> rtl/core/humidity_temp_compensate_check_top.sv
// ----------------------------------------------------------------------------
// humidity_temp_compensate_check_top
// Temperature offset, compensated humidity with clamping, and CRC-8 checks
// of the raw temperature and humidity words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  sample   in         sample_valid/sample_stall sample_t
//  result   out        result_valid/result_stall result_t
//  cfg      in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  One request enters per cycle while sample_stall is low; the path runs through
//  stages 1 to 3, the pipelined divide by 100, and stages 4 to 6.
//  Every stage holds on stall and advances into an empty slot, so bubbles fill.
//  Reset clears the valid bits and loads the command codes 3 and 5.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module humidity_temp_compensate_check_top #(
	parameter int FRACTION_BITS = htcc_pkg::FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  htcc_pkg::sample_t                sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output htcc_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [htcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);

	localparam int F     = FRACTION_BITS;
	localparam int C2W   = F - 4;
	localparam int T1W   = F - 6;
	localparam int T2W   = F - 13;
	localparam int C3W   = F - 14;
	localparam int C2RHW = F + 12;
	localparam int CFW   = F + 3;
	localparam int C3RHW = F + 18;
	localparam int PW    = F + 19;
	localparam int SW    = F + 18;
	localparam int XW    = SW + 7;
	localparam int HW    = XW - F;
	localparam int SIDE_W = SW + 20;

	localparam logic [C2W-1:0] C2_Q   = C2W'((64'd405 << F) / 64'd10000);
	localparam logic [C3W-1:0] C3_Q   = C3W'((64'd28 << F) / 64'd10000000);
	localparam logic [T1W-1:0] T1_Q   = T1W'((64'd1 << F) / 64'd100);
	localparam logic [T2W-1:0] T2_Q   = T2W'((64'd8 << F) / 64'd100000);
	localparam logic [SW-1:0]  C1_MAG = SW'(64'd4 << F);

	logic [7:0] temp_cmd_q;
	logic [7:0] humi_cmd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cmd_q <= htcc_pkg::TEMP_CMD_RESET;
			humi_cmd_q <= htcc_pkg::HUMI_CMD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				htcc_pkg::CFG_TEMP_CMD: temp_cmd_q <= cfg_data;
				htcc_pkg::CFG_HUMI_CMD: humi_cmd_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic div_in_ready;
	logic div_out_valid;
	logic [PW-1:0]     div_q;
	logic [SIDE_W-1:0] div_side_in;
	logic [SIDE_W-1:0] div_side_out;

	assign en_s6 = !v_s6 || !result_stall;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || div_in_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign sample_stall = !en_s1;

	// stage 1: raw products, offsets, command byte into the CRCs
	logic [31:0]        rh2_s1;
	logic [C2RHW-1:0]   c2rh_s1;
	logic [CFW-1:0]     t2rh_s1;
	logic [15:0]        absdt_s1;
	logic               dtneg_s1;
	logic signed [16:0] temp_s1;
	logic [7:0]         tcrc_s1, hcrc_s1;
	logic [7:0]         traw_lo_s1, traw_hi_s1, hraw_lo_s1, hraw_hi_s1;
	logic [7:0]         tsum_s1, hsum_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rh2_s1     <= 32'(sample.raw_humidity) * 32'(sample.raw_humidity);
			c2rh_s1    <= C2RHW'(C2_Q) * C2RHW'(sample.raw_humidity);
			t2rh_s1    <= CFW'(T2_Q) * CFW'(sample.raw_humidity);
			dtneg_s1   <= sample.raw_temperature < htcc_pkg::DT_OFFSET;
			absdt_s1   <= (sample.raw_temperature < htcc_pkg::DT_OFFSET)
				? htcc_pkg::DT_OFFSET - sample.raw_temperature
				: sample.raw_temperature - htcc_pkg::DT_OFFSET;
			temp_s1    <= $signed({1'b0, sample.raw_temperature} - htcc_pkg::TEMP_OFFSET);
			tcrc_s1    <= htcc_pkg::crc8_byte(8'h00, temp_cmd_q);
			hcrc_s1    <= htcc_pkg::crc8_byte(8'h00, humi_cmd_q);
			traw_hi_s1 <= sample.raw_temperature[15:8];
			traw_lo_s1 <= sample.raw_temperature[7:0];
			hraw_hi_s1 <= sample.raw_humidity[15:8];
			hraw_lo_s1 <= sample.raw_humidity[7:0];
			tsum_s1    <= sample.temp_checksum;
			hsum_s1    <= sample.humi_checksum;
		end
	end

	// stage 2: quadratic term, correction coefficient, high bytes
	logic [C3RHW-1:0]   c3rh2_s2;
	logic [CFW-1:0]     coef_s2;
	logic [SW-1:0]      lin_s2;
	logic [15:0]        absdt_s2;
	logic               dtneg_s2;
	logic signed [16:0] temp_s2;
	logic [7:0]         tcrc_s2, hcrc_s2, traw_lo_s2, hraw_lo_s2, tsum_s2, hsum_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			c3rh2_s2   <= C3RHW'(C3_Q) * C3RHW'(rh2_s1);
			coef_s2    <= CFW'(T1_Q) + t2rh_s1;
			lin_s2     <= SW'(c2rh_s1) - C1_MAG;
			absdt_s2   <= absdt_s1;
			dtneg_s2   <= dtneg_s1;
			temp_s2    <= temp_s1;
			tcrc_s2    <= htcc_pkg::crc8_byte(tcrc_s1, traw_hi_s1);
			hcrc_s2    <= htcc_pkg::crc8_byte(hcrc_s1, hraw_hi_s1);
			traw_lo_s2 <= traw_lo_s1;
			hraw_lo_s2 <= hraw_lo_s1;
			tsum_s2    <= tsum_s1;
			hsum_s2    <= hsum_s1;
		end
	end

	// stage 3: correction product, linear sum, low bytes
	logic [PW-1:0]      prod_s3;
	logic [SW-1:0]      lin_s3;
	logic               dtneg_s3;
	logic signed [16:0] temp_s3;
	logic [7:0]         tcrc_s3, hcrc_s3, tsum_s3, hsum_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_s3  <= PW'(coef_s2) * PW'(absdt_s2);
			lin_s3   <= lin_s2 - SW'(c3rh2_s2);
			dtneg_s3 <= dtneg_s2;
			temp_s3  <= temp_s2;
			tcrc_s3  <= htcc_pkg::crc8_byte(tcrc_s2, traw_lo_s2);
			hcrc_s3  <= htcc_pkg::crc8_byte(hcrc_s2, hraw_lo_s2);
			tsum_s3  <= tsum_s2;
			hsum_s3  <= hsum_s2;
		end
	end

	assign div_side_in = {
		temp_s3,
		htcc_pkg::reverse8(tcrc_s3) == tsum_s3,
		htcc_pkg::reverse8(hcrc_s3) == hsum_s3,
		dtneg_s3,
		lin_s3
	};

	htcc_div100 #(
		.WIDTH  (PW),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (v_s3),
		.in_ready     (div_in_ready),
		.in_dividend  (prod_s3),
		.in_side      (div_side_in),
		.out_valid    (div_out_valid),
		.out_ready    (en_s4),
		.out_quotient (div_q),
		.out_side     (div_side_out)
	);

	// stage 4: signed correction added to the linear term
	logic [SW-1:0] q_mag;
	logic [SW-1:0] corr;

	assign q_mag = SW'(div_q);
	assign corr  = div_side_out[SW] ? (SW'(0) - q_mag) : q_mag;

	logic signed [SW-1:0] total_s4;
	logic signed [16:0]   temp_s4;
	logic                 tok_s4, hok_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			total_s4 <= $signed(div_side_out[SW-1:0] + corr);
			temp_s4  <= $signed(div_side_out[SW+19:SW+3]);
			tok_s4   <= div_side_out[SW+2];
			hok_s4   <= div_side_out[SW+1];
		end
	end

	// stage 5: scale to hundredths
	logic signed [XW-1:0] total_ext;
	assign total_ext = XW'(total_s4);

	logic signed [XW-1:0] x100_s5;
	logic signed [16:0]   temp_s5;
	logic                 tok_s5, hok_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			x100_s5 <= (total_ext <<< 6) + (total_ext <<< 5) + (total_ext <<< 2);
			temp_s5 <= temp_s4;
			tok_s5  <= tok_s4;
			hok_s5  <= hok_s4;
		end
	end

	// stage 6: drop fraction, clamp, output register
	logic [HW-1:0] whole;
	logic [13:0]   humi_clamped;

	assign whole = x100_s5[XW-1:F];

	always_comb begin
		if (x100_s5[XW-1] || whole < HW'(htcc_pkg::HUMI_MIN)) begin
			humi_clamped = htcc_pkg::HUMI_MIN;
		end else if (whole > HW'(htcc_pkg::HUMI_MAX)) begin
			humi_clamped = htcc_pkg::HUMI_MAX;
		end else begin
			humi_clamped = whole[13:0];
		end
	end

	htcc_pkg::result_t res_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			res_s6.temperature_centi <= temp_s5;
			res_s6.humidity_centi    <= humi_clamped;
			res_s6.temp_crc_ok       <= tok_s5;
			res_s6.humi_crc_ok       <= hok_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= div_out_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	assign result_valid = v_s6;
	assign result       = res_s6;

endmodule

>>> dv/tb_humidity_temp_compensate_check_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_humidity_temp_compensate_check_top
// Self-checking bench for the humidity and temperature compensation block.
// A local fixed-point predictor computes temperature, clamped humidity and
// both checksum flags for every accepted request.
// Results are compared in order against a queue of expected readings.
// The run covers directed extremes, clamping, and command code writes,
// including writes to unused indexes.
// Three random phases follow, with different sender idle and receiver
// stall rates.
// ----------------------------------------------------------------------------
module tb_humidity_temp_compensate_check_top;

	localparam int LATENCY = 6 + (htcc_pkg::FRACTION_BITS + 19 + 7) / 8;

	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	localparam longint Q_ONE     = longint'(1) << htcc_pkg::FRACTION_BITS;
	localparam longint K_OFS     = -4 * Q_ONE;
	localparam longint K_LIN     = (405 * Q_ONE) / 10000;
	localparam longint K_SQR     = (28 * Q_ONE) / 10000000;
	localparam longint K_TEMP    = Q_ONE / 100;
	localparam longint K_TEMP_RH = (8 * Q_ONE) / 100000;

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             sample_valid = 1'b0;
	logic                             sample_stall;
	htcc_pkg::sample_t                sample       = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	htcc_pkg::result_t                result;
	logic                             cfg_valid    = 1'b0;
	logic                             cfg_ready;
	logic [htcc_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [7:0]                       cfg_data     = '0;

	logic [7:0] temp_code = htcc_pkg::TEMP_CMD_RESET;
	logic [7:0] humi_code = htcc_pkg::HUMI_CMD_RESET;

	htcc_pkg::result_t pending_results[$];
	htcc_pkg::result_t want;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int n_readings     = 0;
	int n_checked      = 0;
	int n_writes       = 0;
	int n_mismatch     = 0;

	humidity_temp_compensate_check_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	function automatic logic [7:0] sensor_checksum(input logic [7:0] cmd, input logic [15:0] word);
		logic [23:0] stream;
		logic [7:0]  c;
		logic [7:0]  r;
		logic        fb;
		stream = {cmd, word};
		c = 8'h00;
		for (int i = 23; i >= 0; i--) begin
			fb = c[7] ^ stream[i];
			c = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ htcc_pkg::CRC_POLY;
			end
		end
		for (int k = 0; k < 8; k++) begin
			r[k] = c[7 - k];
		end
		return r;
	endfunction

	function automatic htcc_pkg::result_t compensate_reading(input htcc_pkg::sample_t s);
		longint            rt;
		longint            rh;
		longint            dt;
		longint            lin;
		longint            slope;
		longint            sum;
		longint            centi;
		longint            tc;
		htcc_pkg::result_t r;
		rt = s.raw_temperature;
		rh = s.raw_humidity;
		dt = rt - 6500;
		tc = rt - 4000;
		lin = K_LIN * rh - K_SQR * rh * rh + K_OFS;
		slope = K_TEMP + K_TEMP_RH * rh;
		sum = lin + (slope * dt) / 100;
		centi = (sum * 100) / Q_ONE;
		if (centi > 10000) begin
			centi = 10000;
		end
		if (centi < 10) begin
			centi = 10;
		end
		r.temperature_centi = tc[16:0];
		r.humidity_centi = centi[13:0];
		r.temp_crc_ok = (sensor_checksum(temp_code, s.raw_temperature) == s.temp_checksum);
		r.humi_crc_ok = (sensor_checksum(humi_code, s.raw_humidity) == s.humi_checksum);
		return r;
	endfunction

	function automatic htcc_pkg::sample_t random_reading();
		htcc_pkg::sample_t s;
		logic [7:0]        good;
		s.raw_temperature = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
		s.raw_humidity = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4095));
		good = sensor_checksum(temp_code, s.raw_temperature);
		case ($urandom_range(0, 3))
			0, 1: s.temp_checksum = good;
			2: s.temp_checksum = good ^ (8'h01 << $urandom_range(0, 7));
			default: s.temp_checksum = 8'($urandom);
		endcase
		good = sensor_checksum(humi_code, s.raw_humidity);
		case ($urandom_range(0, 3))
			0, 1: s.humi_checksum = good;
			2: s.humi_checksum = good ^ (8'h01 << $urandom_range(0, 7));
			default: s.humi_checksum = 8'($urandom);
		endcase
		return s;
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				n_mismatch++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (result.temperature_centi !== want.temperature_centi) begin
					$display("%0t: temperature_centi expected %0d actual %0d",
						$time, want.temperature_centi, result.temperature_centi);
					n_mismatch++;
				end
				if (result.humidity_centi !== want.humidity_centi) begin
					$display("%0t: humidity_centi expected %0d actual %0d",
						$time, want.humidity_centi, result.humidity_centi);
					n_mismatch++;
				end
				if (result.temp_crc_ok !== want.temp_crc_ok) begin
					$display("%0t: temp_crc_ok expected %0b actual %0b",
						$time, want.temp_crc_ok, result.temp_crc_ok);
					n_mismatch++;
				end
				if (result.humi_crc_ok !== want.humi_crc_ok) begin
					$display("%0t: humi_crc_ok expected %0b actual %0b",
						$time, want.humi_crc_ok, result.humi_crc_ok);
					n_mismatch++;
				end
			end
		end
	end

	// enter and leave on a falling edge
	task automatic send_reading(input htcc_pkg::sample_t s);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		pending_results.push_back(compensate_reading(s));
		n_readings++;
		@(negedge clk);
	endtask

	task automatic send_directed(input int t, input int h, input bit t_ok, input bit h_ok);
		htcc_pkg::sample_t s;
		logic [7:0]        ct;
		logic [7:0]        ch;
		ct = sensor_checksum(temp_code, 16'(t));
		ch = sensor_checksum(humi_code, 16'(h));
		s.raw_temperature = 16'(t);
		s.raw_humidity = 16'(h);
		s.temp_checksum = t_ok ? ct : ~ct;
		s.humi_checksum = h_ok ? ch : ~ch;
		send_reading(s);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == htcc_pkg::CFG_TEMP_CMD) begin
			temp_code = val;
		end else if (idx == htcc_pkg::CFG_HUMI_CMD) begin
			humi_code = val;
		end
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_reset_codes();
		send_directed(6500, 1500, 1, 1);
		send_directed(6500, 1500, 0, 1);
		send_directed(6500, 1500, 1, 0);
		send_directed(2500, 2000, 1, 1);
	endtask

	task automatic test_field_extremes();
		send_reading('{16'h0000, 8'h00, 16'h0000, 8'h00});
		send_reading('{16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF});
		send_directed(0, 65535, 1, 1);
		send_directed(65535, 0, 1, 1);
	endtask

	task automatic test_humidity_clamps();
		send_directed(6500, 3500, 1, 1);
		send_directed(6500, 3300, 1, 1);
		send_directed(12000, 3000, 1, 1);
		send_directed(6500, 99, 1, 1);
		send_directed(6500, 102, 1, 1);
		send_directed(6500, 104, 1, 1);
		send_directed(0, 1500, 1, 1);
		send_directed(2000, 500, 0, 0);
	endtask

	task automatic test_command_codes();
		write_register(htcc_pkg::CFG_TEMP_CMD, 8'h00);
		write_register(htcc_pkg::CFG_HUMI_CMD, 8'hFF);
		send_directed(4321, 1234, 1, 1);
		send_directed(9000, 2500, 1, 0);
		write_register(htcc_pkg::CFG_TEMP_CMD, 8'hFF);
		write_register(htcc_pkg::CFG_HUMI_CMD, 8'h00);
		send_directed(4321, 1234, 1, 1);
		send_directed(9000, 2500, 0, 1);
		// unused indexes must leave both codes alone
		write_register(CFG_SPARE_LO, 8'hAA);
		write_register(CFG_SPARE_HI, 8'h55);
		send_directed(7000, 1800, 1, 1);
		send_directed(7000, 1800, 0, 0);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n,
		input logic [7:0] tcode, input logic [7:0] hcode);
		write_register(htcc_pkg::CFG_TEMP_CMD, tcode);
		write_register(htcc_pkg::CFG_HUMI_CMD, hcode);
		write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		repeat (n) begin
			send_reading(random_reading());
		end
		wait_drained();
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_codes();
		test_field_extremes();
		test_humidity_clamps();
		test_command_codes();
		test_random_traffic(16, 85, 250, 8'hFF, 8'h00);
		test_random_traffic(85, 16, 250, 8'($urandom), 8'($urandom));
		test_random_traffic(0, 0, 250, htcc_pkg::TEMP_CMD_RESET, htcc_pkg::HUMI_CMD_RESET);
		wait_drained();
		sink_stall_pct = 0;
		repeat (2 * LATENCY) @(negedge clk);
		$display("Sent %0d readings, checked %0d results, %0d register writes.",
			n_readings, n_checked, n_writes);
		$display("Covered clamp limits, checksum hits and misses, and code changes.");
		if (n_mismatch == 0) begin
			$display("tb_humidity_temp_compensate_check_top OK");
		end else begin
			$display("tb_humidity_temp_compensate_check_top NOT OK");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results still pending", pending_results.size());
		$display("tb_humidity_temp_compensate_check_top NOT OK");
		$finish;
	end

endmodule
